@@ src/mbtc_pkg.sv @@
// Package for the Modbus TCP client frame engine.
// Holds command, kind and status codes, function code table and result types.
// No dependencies.
package mbtc_pkg;

    localparam logic [1:0] CMD_REQUEST   = 2'd0;
    localparam logic [1:0] CMD_RX_BYTE   = 2'd1;
    localparam logic [1:0] CMD_RECONNECT = 2'd2;

    localparam logic [1:0] OP_READ_COILS = 2'd0;
    localparam logic [1:0] OP_WRITE_COIL = 2'd1;
    localparam logic [1:0] OP_READ_REGS  = 2'd2;
    localparam logic [1:0] OP_WRITE_REG  = 2'd3;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_EXCEPTION  = 4'd1;
    localparam logic [3:0] ST_BAD_COUNT  = 4'd2;
    localparam logic [3:0] ST_NOT_CONN   = 4'd3;
    localparam logic [3:0] ST_BUSY       = 4'd4;
    localparam logic [3:0] ST_BAD_LENGTH = 4'd5;
    localparam logic [3:0] ST_TOO_SHORT  = 4'd6;
    localparam logic [3:0] ST_HEADER     = 4'd7;
    localparam logic [3:0] ST_FUNCTION   = 4'd8;
    localparam logic [3:0] ST_BYTE_COUNT = 4'd9;
    localparam logic [3:0] ST_ECHO       = 4'd10;
    localparam logic [3:0] ST_UNEXPECTED = 4'd11;
    localparam logic [3:0] ST_NONE       = 4'd12;

    localparam logic [7:0]  UNIT_ID_RESET   = 8'd1;
    localparam logic [7:0]  EXCEPTION_FLAG  = 8'h80;
    localparam logic [15:0] COIL_ON         = 16'hFF00;
    localparam logic [15:0] MAX_COILS       = 16'd2000;
    localparam logic [15:0] MAX_REGS        = 16'd125;
    localparam logic [15:0] MAX_LENGTH      = 16'd254;
    localparam logic [8:0]  FIRST_DATA_POS  = 9'd9;

    function automatic logic [7:0] fcode(input logic [1:0] op);
        logic [7:0] f;
        case (op)
            OP_READ_COILS: f = 8'd1;
            OP_WRITE_COIL: f = 8'd5;
            OP_READ_REGS:  f = 8'd3;
            default:       f = 8'd6;
        endcase
        return f;
    endfunction

    // One queued output item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] data_value;
        logic [10:0] data_index;
        logic [3:0]  status;
        logic [7:0]  exception_code;
    } result_t;

    // Burst descriptor handed from the engine to the output sequencer.
    typedef enum logic [1:0] {
        BURST_NONE   = 2'd0,
        BURST_SINGLE = 2'd1,
        BURST_FRAME  = 2'd2,
        BURST_COILS  = 2'd3
    } burst_kind_t;

    typedef struct packed {
        burst_kind_t kind;
        result_t     single;     // status or register word
        logic [95:0] frame;      // 12 request bytes, byte 0 in [95:88]
        logic [7:0]  coil_bits;
        logic [10:0] coil_base;
        logic [3:0]  coil_count; // 1..8 coil values
        logic        tail_valid; // a status follows the coils
        result_t     tail;
    } burst_t;

endpackage

@@ src/mbtc_engine.sv @@
// State engine: request checks, framing, response parsing.
// Produces one burst descriptor per accepted item. Depends on mbtc_pkg.
module mbtc_engine
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_data,
    input  logic                  step,
    input  logic [1:0]            command,
    input  logic [1:0]            operation,
    input  logic [15:0]           start_address,
    input  logic [15:0]           quantity_or_value,
    input  logic [7:0]            rx_byte,
    output mbtc_pkg::burst_t      burst
);

    logic [7:0]  unit_id_reg;
    logic [15:0] trans_reg,   trans_next;
    logic        fault_reg,   fault_next;
    logic        pend_reg,    pend_next;
    logic [1:0]  pop_reg,     pop_next;
    logic [10:0] pqty_reg,    pqty_next;
    logic [31:0] echo_reg,    echo_next;
    logic [8:0]  pos_reg,     pos_next;
    logic [15:0] flen_reg,    flen_next;
    logic [3:0]  ferr_reg,    ferr_next;
    logic [7:0]  exc_reg,     exc_next;
    logic [10:0] vidx_reg,    vidx_next;
    logic [7:0]  hold_reg,    hold_next;

    // Helpers for response parsing.
    logic        is_read_pend;
    logic [7:0]  fc_pend;
    logic [15:0] expect_bytes;
    logic [15:0] flen_cur;
    logic        len_ok;
    logic [8:0]  frame_end;
    logic [11:0] coil_rem;
    logic [3:0]  coil_n;
    logic [7:0]  echo_byte;
    logic        is_read_in;
    logic [15:0] wire_val;
    logic [15:0] trans_inc;

    always_comb
    begin
        is_read_pend = (pop_reg == mbtc_pkg::OP_READ_COILS) ||
                       (pop_reg == mbtc_pkg::OP_READ_REGS);
        fc_pend      = mbtc_pkg::fcode(pop_reg);
        expect_bytes = (pop_reg == mbtc_pkg::OP_READ_COILS)
                       ? {8'd0, pqty_reg[10:3]} + {15'd0, |pqty_reg[2:0]}
                       : {4'd0, pqty_reg, 1'b0};
        is_read_in   = (operation == mbtc_pkg::OP_READ_COILS) ||
                       (operation == mbtc_pkg::OP_READ_REGS);
        wire_val     = (operation == mbtc_pkg::OP_WRITE_COIL)
                       ? ((quantity_or_value != 16'd0) ? mbtc_pkg::COIL_ON : 16'd0)
                       : quantity_or_value;
        trans_inc    = trans_reg + 16'd1;
        coil_rem     = {1'b0, pqty_reg} - {1'b0, vidx_reg};
        coil_n       = (vidx_reg >= pqty_reg) ? 4'd0
                       : ((coil_rem > 12'd8) ? 4'd8 : coil_rem[3:0]);
        // Echo bytes 9, 10 and 11 carry address low, value high and value low.
        case (pos_reg[1:0])
            2'd1:    echo_byte = echo_reg[23:16];
            2'd2:    echo_byte = echo_reg[15:8];
            default: echo_byte = echo_reg[7:0];
        endcase
    end

    // Next state and burst.
    always_comb
    begin
        trans_next = trans_reg;  fault_next = fault_reg;  pend_next = pend_reg;
        pop_next   = pop_reg;    pqty_next  = pqty_reg;   echo_next = echo_reg;
        pos_next   = pos_reg;    flen_next  = flen_reg;   ferr_next = ferr_reg;
        exc_next   = exc_reg;    vidx_next  = vidx_reg;   hold_next = hold_reg;
        flen_cur   = flen_reg;
        len_ok     = 1'b0;
        frame_end  = 9'd6;
        burst      = '0;
        burst.kind = mbtc_pkg::BURST_NONE;
        burst.single.kind = mbtc_pkg::KIND_STATUS;
        burst.tail.kind   = mbtc_pkg::KIND_STATUS;

        case (command)
            mbtc_pkg::CMD_REQUEST:
            begin
                burst.kind = mbtc_pkg::BURST_SINGLE;
                if (is_read_in && (quantity_or_value == 16'd0 ||
                    quantity_or_value > ((operation == mbtc_pkg::OP_READ_COILS)
                                         ? mbtc_pkg::MAX_COILS : mbtc_pkg::MAX_REGS)))
                    burst.single.status = mbtc_pkg::ST_BAD_COUNT;
                else if (fault_reg)
                    burst.single.status = mbtc_pkg::ST_NOT_CONN;
                else if (pend_reg)
                    burst.single.status = mbtc_pkg::ST_BUSY;
                else
                begin
                    burst.kind  = mbtc_pkg::BURST_FRAME;
                    burst.frame = {trans_inc, 16'd0, 16'd6, unit_id_reg,
                                   mbtc_pkg::fcode(operation), start_address, wire_val};
                    trans_next = trans_inc;
                    pend_next  = 1'b1;
                    pop_next   = operation;
                    pqty_next  = is_read_in ? quantity_or_value[10:0] : 11'd0;
                    echo_next  = {start_address, wire_val};
                    pos_next   = 9'd0;
                    flen_next  = 16'd0;
                    ferr_next  = mbtc_pkg::ST_NONE;
                    exc_next   = 8'd0;
                    vidx_next  = 11'd0;
                    hold_next  = 8'd0;
                end
            end
            mbtc_pkg::CMD_RX_BYTE:
            begin
                if (!pend_reg)
                begin
                    burst.kind = mbtc_pkg::BURST_SINGLE;
                    burst.single.status = mbtc_pkg::ST_UNEXPECTED;
                end
                else
                begin
                    case (pos_reg)
                        9'd0: if (rx_byte != trans_reg[15:8]) ferr_next = mbtc_pkg::ST_HEADER;
                        9'd1: if (rx_byte != trans_reg[7:0]) ferr_next = mbtc_pkg::ST_HEADER;
                        9'd2, 9'd3: if (rx_byte != 8'd0) ferr_next = mbtc_pkg::ST_HEADER;
                        9'd4: flen_cur = {rx_byte, 8'd0};
                        9'd5: flen_cur = {flen_reg[15:8], rx_byte};
                        default: ;
                    endcase
                    // note_min for header codes; ferr only decreases there.
                    if (pos_reg <= 9'd3 && ferr_next > ferr_reg) ferr_next = ferr_reg;
                    if (pos_reg == 9'd5 && flen_cur == 16'd2 &&
                        ferr_reg > mbtc_pkg::ST_TOO_SHORT)
                        ferr_next = mbtc_pkg::ST_TOO_SHORT;
                    flen_next = flen_cur;
                    len_ok    = (flen_cur >= 16'd2) && (flen_cur <= mbtc_pkg::MAX_LENGTH);
                    frame_end = len_ok ? (9'd5 + flen_cur[8:0]) : 9'd6;

                    if (pos_reg == 9'd6)
                    begin
                        if (!len_ok)
                        begin
                            if (ferr_reg > mbtc_pkg::ST_BAD_LENGTH)
                                ferr_next = mbtc_pkg::ST_BAD_LENGTH;
                        end
                        else if (rx_byte != unit_id_reg && ferr_reg > mbtc_pkg::ST_HEADER)
                            ferr_next = mbtc_pkg::ST_HEADER;
                    end
                    else if (pos_reg == 9'd7)
                    begin
                        if (ferr_reg == mbtc_pkg::ST_NONE)
                        begin
                            if (rx_byte == (fc_pend | mbtc_pkg::EXCEPTION_FLAG))
                                ferr_next = mbtc_pkg::ST_EXCEPTION;
                            else if (rx_byte != fc_pend)
                                ferr_next = mbtc_pkg::ST_FUNCTION;
                            else if (!is_read_pend && flen_reg != 16'd6)
                                ferr_next = mbtc_pkg::ST_ECHO;
                        end
                    end
                    else if (pos_reg == 9'd8)
                    begin
                        if (ferr_reg == mbtc_pkg::ST_EXCEPTION)
                            exc_next = rx_byte;
                        else if (is_read_pend)
                        begin
                            if ((flen_reg != expect_bytes + 16'd3 ||
                                 {8'd0, rx_byte} != expect_bytes) &&
                                ferr_reg == mbtc_pkg::ST_NONE)
                                ferr_next = mbtc_pkg::ST_BYTE_COUNT;
                        end
                        else if (rx_byte != echo_reg[31:24] && ferr_reg == mbtc_pkg::ST_NONE)
                            ferr_next = mbtc_pkg::ST_ECHO;
                    end
                    else if (pos_reg >= 9'd9 && ferr_reg == mbtc_pkg::ST_NONE)
                    begin
                        if (!is_read_pend)
                        begin
                            if (pos_reg <= 9'd11 && rx_byte != echo_byte)
                                ferr_next = mbtc_pkg::ST_ECHO;
                        end
                        else if (pop_reg == mbtc_pkg::OP_READ_COILS)
                        begin
                            if (coil_n != 4'd0)
                            begin
                                burst.kind       = mbtc_pkg::BURST_COILS;
                                burst.coil_bits  = rx_byte;
                                burst.coil_base  = vidx_reg;
                                burst.coil_count = coil_n;
                                vidx_next        = vidx_reg + {7'd0, coil_n};
                            end
                        end
                        else if (pos_reg[0])
                            hold_next = rx_byte;   // (pos-9) even: high byte
                        else
                        begin
                            burst.kind              = mbtc_pkg::BURST_SINGLE;
                            burst.single.kind       = mbtc_pkg::KIND_DATA;
                            burst.single.data_value = {hold_reg, rx_byte};
                            burst.single.data_index = vidx_reg;
                            vidx_next               = vidx_reg + 11'd1;
                        end
                    end

                    if (pos_reg >= 9'd6 && pos_reg == frame_end)
                    begin
                        burst.tail_valid = 1'b1;
                        burst.tail.status =
                            (ferr_next == mbtc_pkg::ST_NONE) ? mbtc_pkg::ST_OK : ferr_next;
                        burst.tail.exception_code =
                            (ferr_next == mbtc_pkg::ST_EXCEPTION) ? exc_next : 8'd0;
                        if (ferr_next >= mbtc_pkg::ST_BAD_LENGTH &&
                            ferr_next <= mbtc_pkg::ST_ECHO)
                            fault_next = 1'b1;
                        pend_next = 1'b0;
                        pos_next  = 9'd0;
                        if (burst.kind == mbtc_pkg::BURST_NONE)
                        begin
                            burst.kind       = mbtc_pkg::BURST_SINGLE;
                            burst.single     = burst.tail;
                            burst.tail_valid = 1'b0;
                        end
                    end
                    else
                        pos_next = pos_reg + 9'd1;
                end
            end
            mbtc_pkg::CMD_RECONNECT:
            begin
                fault_next = 1'b0;  pend_next = 1'b0;  trans_next = 16'd0;
                pos_next   = 9'd0;  flen_next = 16'd0; ferr_next  = mbtc_pkg::ST_NONE;
                exc_next   = 8'd0;  vidx_next = 11'd0; hold_next  = 8'd0;
                burst.kind = mbtc_pkg::BURST_SINGLE;
                burst.single.status = mbtc_pkg::ST_OK;
            end
            default: ;
        endcase
        if (!step)
            burst.kind = mbtc_pkg::BURST_NONE;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_id_reg <= mbtc_pkg::UNIT_ID_RESET;
            trans_reg <= '0; fault_reg <= 1'b0; pend_reg <= 1'b0; pop_reg <= '0;
            pqty_reg  <= '0; echo_reg  <= '0;   pos_reg  <= '0;   flen_reg <= '0;
            ferr_reg  <= mbtc_pkg::ST_NONE;     exc_reg  <= '0;   vidx_reg <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                unit_id_reg <= cfg_data;
            if (step)
            begin
                trans_reg <= trans_next; fault_reg <= fault_next; pend_reg <= pend_next;
                pop_reg   <= pop_next;   pqty_reg  <= pqty_next;  echo_reg <= echo_next;
                pos_reg   <= pos_next;   flen_reg  <= flen_next;  ferr_reg <= ferr_next;
                exc_reg   <= exc_next;   vidx_reg  <= vidx_next;  hold_reg <= hold_next;
            end
        end
    end

endmodule

@@ src/mbtc_sequencer.sv @@
// Output sequencer: holds one burst and plays its results one per cycle
// while out_ready is high. Depends on mbtc_pkg.
module mbtc_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  mbtc_pkg::burst_t      burst,
    output logic                  idle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mbtc_pkg::result_t     res,
    output logic                  res_last
);

    mbtc_pkg::burst_t burst_reg;
    logic [3:0]       idx_reg;
    logic             busy_reg;
    logic [3:0]       count;
    logic             done;

    // Number of results in the held burst.
    always_comb
    begin
        case (burst_reg.kind)
            mbtc_pkg::BURST_FRAME: count = 4'd12;
            mbtc_pkg::BURST_COILS: count = burst_reg.coil_count + {3'd0, burst_reg.tail_valid};
            default:               count = 4'd1 + {3'd0, burst_reg.tail_valid};
        endcase
        res = '0;
        case (burst_reg.kind)
            mbtc_pkg::BURST_FRAME:
            begin
                res.kind    = mbtc_pkg::KIND_TX;
                res.tx_byte = burst_reg.frame[8'd95 - {idx_reg, 3'd0} -: 8];
            end
            mbtc_pkg::BURST_COILS:
            begin
                if (idx_reg == burst_reg.coil_count)
                    res = burst_reg.tail;
                else
                begin
                    res.kind       = mbtc_pkg::KIND_DATA;
                    res.data_value = {15'd0, burst_reg.coil_bits[idx_reg[2:0]]};
                    res.data_index = burst_reg.coil_base + {7'd0, idx_reg};
                end
            end
            default:
            begin
                // A register word may be followed by the frame status.
                if (idx_reg == 4'd0)
                    res = burst_reg.single;
                else
                    res = burst_reg.tail;
            end
        endcase
        res_last  = (idx_reg == count - 4'd1);
        out_valid = busy_reg;
        done      = busy_reg && out_ready && res_last;
        idle      = !busy_reg || done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load && burst.kind != mbtc_pkg::BURST_NONE)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg && out_ready)
            idx_reg <= idx_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
    end

endmodule

@@ src/modbus_tcp_client_frame_engine_unit.sv @@
// Top level of the Modbus TCP client frame engine.
// Depends on mbtc_pkg, mbtc_engine and mbtc_sequencer.
//
// Channel   Signals                                  Role
// in        in_valid/in_ready, command..rx_byte      command items
// out       out_valid/out_ready, kind..last          result items
// cfg       cfg_valid/cfg_ready, cfg_data            unit_id register
//
// An item is processed in the cycle it is accepted; its results (0 to 12)
// leave the burst register one per cycle while out_ready is high, so a
// framed request gives 12 results and a response byte 0 to 9. A new
// item is accepted in the cycle the last result of the previous burst is
// taken. Reset clears all protocol state and sets unit_id to 1.
module modbus_tcp_client_frame_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [1:0]  operation,
    input  logic [15:0] start_address,
    input  logic [15:0] quantity_or_value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic [15:0] data_value,
    output logic [10:0] data_index,
    output logic [3:0]  status,
    output logic [7:0]  exception_code,
    output logic        last
);

    mbtc_pkg::burst_t  burst;
    mbtc_pkg::result_t res;
    logic              idle;
    logic              step;

    assign cfg_ready = 1'b1;
    assign in_ready  = idle;
    assign step      = in_valid && idle;

    mbtc_engine u_engine
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .step              (step),
        .command           (command),
        .operation         (operation),
        .start_address     (start_address),
        .quantity_or_value (quantity_or_value),
        .rx_byte           (rx_byte),
        .burst             (burst)
    );

    mbtc_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .burst     (burst),
        .idle      (idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .res_last  (last)
    );

    assign kind           = res.kind;
    assign tx_byte        = res.tx_byte;
    assign data_value     = res.data_value;
    assign data_index     = res.data_index;
    assign status         = res.status;
    assign exception_code = res.exception_code;

endmodule

@@ src/mbtc_checker.sv @@
// Port-level checker for the Modbus TCP client frame engine.
// Depends on mbtc_pkg; bound to modbus_tcp_client_frame_engine_unit.
module mbtc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [3:0]  status,
    input logic [7:0]  exception_code,
    input logic        last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("stalled result changed");

    // A status result always ends its transaction.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == mbtc_pkg::KIND_STATUS |-> last)
        else $error("status not last");

    // Exception code only travels with an exception status.
    a_exc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exception_code != 8'd0 |-> status == mbtc_pkg::ST_EXCEPTION)
        else $error("stray exception code");

    // Input is taken only while no burst is outstanding or the last goes.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(out_ready && last) |-> !in_ready)
        else $error("input accepted mid burst");

endmodule

bind modbus_tcp_client_frame_engine_unit mbtc_checker u_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .status         (status),
    .exception_code (exception_code),
    .last           (last)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the Modbus TCP client frame engine.
// Depends on mbtc_pkg and modbus_tcp_client_frame_engine_unit; it predicts every result
// item from its own model of the protocol and compares the results field by field.
`timescale 1ns / 1ps

module testbench;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] data_value;
        logic [10:0] data_index;
        logic [3:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } frame_result_t;

    // Scoreboard: a protocol model plus the queue of results it predicts.
    class frame_scoreboard;
        frame_result_t pending_results[$];
        int            errors;
        logic [7:0]    unit;
        logic [15:0]   trans_count;
        bit            fault;
        bit            busy;
        logic [1:0]    req_op;
        logic [15:0]   req_qty;
        logic [31:0]   echo_word;
        logic [8:0]    rx_pos;
        logic [15:0]   length_field;
        logic [3:0]    first_err;
        logic [7:0]    exc_code;
        logic [10:0]   word_index;
        logic [7:0]    high_hold;

        function new();
            unit = mbtc_pkg::UNIT_ID_RESET;
            trans_count = 0;
            fault = 0;
            busy = 0;
            req_op = 0;
            req_qty = 0;
            echo_word = 0;
            rx_pos = 0;
            length_field = 0;
            first_err = mbtc_pkg::ST_NONE;
            exc_code = 0;
            word_index = 0;
            high_hold = 0;
            errors = 0;
        endfunction

        function void push(logic [1:0] k, logic [7:0] tx, logic [15:0] v,
                           logic [10:0] idx, logic [3:0] st, logic [7:0] ex);
            frame_result_t r;
            r = '{k, tx, v, idx, st, ex, 1'b0};
            pending_results = {pending_results, r};
        endfunction

        function logic [7:0] func_code(logic [1:0] op);
            case (op)
                mbtc_pkg::OP_READ_COILS: return 8'd1;
                mbtc_pkg::OP_WRITE_COIL: return 8'd5;
                mbtc_pkg::OP_READ_REGS:  return 8'd3;
                default:                 return 8'd6;
            endcase
        endfunction

        // Parse one response byte against the pending request.
        function void take_rx(logic [7:0] b);
            logic [7:0]  fc;
            logic        rd;
            logic [15:0] need;
            logic [8:0]  last_pos;
            logic [3:0]  st;
            fc = func_code(req_op);
            rd = (req_op == mbtc_pkg::OP_READ_COILS || req_op == mbtc_pkg::OP_READ_REGS);
            case (rx_pos)
                0: if (b != trans_count[15:8] && mbtc_pkg::ST_HEADER < first_err)
                       first_err = mbtc_pkg::ST_HEADER;
                1: if (b != trans_count[7:0] && mbtc_pkg::ST_HEADER < first_err)
                       first_err = mbtc_pkg::ST_HEADER;
                2, 3: if (b != 0 && mbtc_pkg::ST_HEADER < first_err)
                          first_err = mbtc_pkg::ST_HEADER;
                4: length_field = {b, 8'h00};
                5:
                begin
                    length_field[7:0] = b;
                    if (length_field == 2 && mbtc_pkg::ST_TOO_SHORT < first_err)
                        first_err = mbtc_pkg::ST_TOO_SHORT;
                end
                6:
                begin
                    if (length_field < 2 || length_field > mbtc_pkg::MAX_LENGTH) begin
                        if (mbtc_pkg::ST_BAD_LENGTH < first_err)
                            first_err = mbtc_pkg::ST_BAD_LENGTH;
                    end else if (b != unit && mbtc_pkg::ST_HEADER < first_err)
                        first_err = mbtc_pkg::ST_HEADER;
                end
                7:
                begin
                    if (first_err == mbtc_pkg::ST_NONE) begin
                        if (b == (fc | mbtc_pkg::EXCEPTION_FLAG))
                            first_err = mbtc_pkg::ST_EXCEPTION;
                        else if (b != fc) first_err = mbtc_pkg::ST_FUNCTION;
                        else if (!rd && length_field != 6) first_err = mbtc_pkg::ST_ECHO;
                    end
                end
                8:
                begin
                    if (first_err == mbtc_pkg::ST_EXCEPTION) exc_code = b;
                    else if (rd) begin
                        need = (req_op == mbtc_pkg::OP_READ_COILS) ? (req_qty + 7) / 8
                                                                   : req_qty * 2;
                        if ((length_field != need + 3 || b != need[7:0] || need[15:8] != 0)
                            && first_err == mbtc_pkg::ST_NONE)
                            first_err = mbtc_pkg::ST_BYTE_COUNT;
                    end else if (b != echo_word[31:24] && first_err == mbtc_pkg::ST_NONE)
                        first_err = mbtc_pkg::ST_ECHO;
                end
                default:
                begin
                    if (first_err == mbtc_pkg::ST_NONE) begin
                        if (!rd) begin
                            if (rx_pos <= 11 && b != echo_word[8 * (11 - rx_pos) +: 8])
                                first_err = mbtc_pkg::ST_ECHO;
                        end else if (req_op == mbtc_pkg::OP_READ_COILS) begin
                            for (int i = 0; i < 8; i++) begin
                                if (word_index < req_qty) begin
                                    push(mbtc_pkg::KIND_DATA, 0, {15'd0, b[i]}, word_index,
                                         0, 0);
                                    word_index++;
                                end
                            end
                        end else if (rx_pos[0] == 1'b1) high_hold = b;
                        else begin
                            push(mbtc_pkg::KIND_DATA, 0, {high_hold, b}, word_index, 0, 0);
                            word_index++;
                        end
                    end
                end
            endcase
            last_pos = (length_field >= 2 && length_field <= mbtc_pkg::MAX_LENGTH) ?
                       9'(5 + length_field) : 9'd6;
            if (rx_pos >= 6 && rx_pos == last_pos) begin
                st = (first_err == mbtc_pkg::ST_NONE) ? mbtc_pkg::ST_OK : first_err;
                push(mbtc_pkg::KIND_STATUS, 0, 0, 0, st,
                     st == mbtc_pkg::ST_EXCEPTION ? exc_code : 8'd0);
                if (st >= mbtc_pkg::ST_BAD_LENGTH && st <= mbtc_pkg::ST_ECHO) fault = 1;
                busy = 0;
                rx_pos = 0;
            end else rx_pos = rx_pos + 1;
        endfunction

        // Note one accepted input transaction and queue its results.
        function void note_input(logic [1:0] cmd, logic [1:0] op, logic [15:0] addr,
                                 logic [15:0] qv, logic [7:0] rx);
            int          queued_at_start;
            logic        rd;
            logic [15:0] wire_val;
            logic [95:0] frame;
            queued_at_start = pending_results.size();
            rd = (op == mbtc_pkg::OP_READ_COILS || op == mbtc_pkg::OP_READ_REGS);
            if (cmd == mbtc_pkg::CMD_REQUEST) begin
                if (rd && (qv == 0 || qv > ((op == mbtc_pkg::OP_READ_COILS)
                                            ? mbtc_pkg::MAX_COILS : mbtc_pkg::MAX_REGS)))
                    push(mbtc_pkg::KIND_STATUS, 0, 0, 0, mbtc_pkg::ST_BAD_COUNT, 0);
                else if (fault) push(mbtc_pkg::KIND_STATUS, 0, 0, 0, mbtc_pkg::ST_NOT_CONN, 0);
                else if (busy) push(mbtc_pkg::KIND_STATUS, 0, 0, 0, mbtc_pkg::ST_BUSY, 0);
                else begin
                    wire_val = (op == mbtc_pkg::OP_WRITE_COIL)
                               ? ((qv != 0) ? mbtc_pkg::COIL_ON : 16'd0) : qv;
                    trans_count++;
                    frame = {trans_count, 16'd0, 16'd6, unit, func_code(op), addr, wire_val};
                    for (int i = 11; i >= 0; i--)
                        push(mbtc_pkg::KIND_TX, frame[8 * i +: 8], 0, 0, 0, 0);
                    busy = 1;
                    req_op = op;
                    req_qty = rd ? qv : 16'd0;
                    echo_word = {addr, wire_val};
                    rx_pos = 0;
                    length_field = 0;
                    first_err = mbtc_pkg::ST_NONE;
                    exc_code = 0;
                    word_index = 0;
                    high_hold = 0;
                end
            end else if (cmd == mbtc_pkg::CMD_RX_BYTE) begin
                if (!busy) push(mbtc_pkg::KIND_STATUS, 0, 0, 0, mbtc_pkg::ST_UNEXPECTED, 0);
                else take_rx(rx);
            end else if (cmd == mbtc_pkg::CMD_RECONNECT) begin
                fault = 0;
                busy = 0;
                trans_count = 0;
                rx_pos = 0;
                length_field = 0;
                first_err = mbtc_pkg::ST_NONE;
                exc_code = 0;
                word_index = 0;
                high_hold = 0;
                push(mbtc_pkg::KIND_STATUS, 0, 0, 0, mbtc_pkg::ST_OK, 0);
            end
            if (pending_results.size() > queued_at_start)
                pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_result(frame_result_t got);
            frame_result_t exp_r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.kind != exp_r.kind || got.tx_byte != exp_r.tx_byte
                || got.data_value != exp_r.data_value || got.data_index != exp_r.data_index
                || got.status != exp_r.status || got.exception_code != exp_r.exception_code
                || got.last != exp_r.last) begin
                $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [1:0]  operation;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_value;
    logic [10:0] data_index;
    logic [3:0]  status;
    logic [7:0]  exception_code;
    logic        last;

    frame_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    longint cycle_count;

    modbus_tcp_client_frame_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .operation(operation), .start_address(start_address),
        .quantity_or_value(quantity_or_value), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .tx_byte(tx_byte),
        .data_value(data_value), .data_index(data_index), .status(status),
        .exception_code(exception_code), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Watchdog on total cycles.
    initial
    begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Result sampling at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{kind, tx_byte, data_value, data_index, status,
                                 exception_code, last});
    end

    // Receiver ready, updated at the falling edge; a hold-off overrides it.
    initial
    begin
        out_ready = 0;
        forever begin
            @(negedge clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                out_ready <= 0;
            end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Drive one input transaction at the falling edge and wait until it is accepted.
    task automatic send_item(logic [1:0] cmd, logic [1:0] op, logic [15:0] addr,
                             logic [15:0] qv, logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid = 1;
        command = cmd;
        operation = op;
        start_address = addr;
        quantity_or_value = qv;
        rx_byte = rx;
        do @(posedge clk); while (!in_ready);
        board.note_input(cmd, op, addr, qv, rx);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_rx(logic [7:0] b);
        send_item(mbtc_pkg::CMD_RX_BYTE, 0, 0, 0, b);
    endtask

    // Write the unit identifier once the block is idle.
    task automatic write_unit(logic [7:0] v);
        while (board.pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid = 1;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        board.unit = v;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // Send a response frame, mostly well formed, with an optional corruption.
    task automatic send_response(int corrupt);
        logic [7:0]  bytes[$];
        logic [15:0] need;
        logic        rd;
        rd = (board.req_op == mbtc_pkg::OP_READ_COILS ||
              board.req_op == mbtc_pkg::OP_READ_REGS);
        bytes = {board.trans_count[15:8], board.trans_count[7:0], 8'd0, 8'd0};
        if (corrupt == 1 && $urandom_range(1)) begin
            bytes = {bytes, 8'd0, 8'd3, board.unit,
                     board.func_code(board.req_op) | mbtc_pkg::EXCEPTION_FLAG,
                     8'($urandom)};
        end else if (rd) begin
            need = (board.req_op == mbtc_pkg::OP_READ_COILS) ? (board.req_qty + 7) / 8
                                                             : board.req_qty * 2;
            bytes = {bytes, need[15:8], 8'(need + 3), board.unit,
                     board.func_code(board.req_op), need[7:0]};
            for (int i = 0; i < need; i++) bytes = {bytes, 8'($urandom)};
        end else begin
            bytes = {bytes, 8'd0, 8'd6, board.unit, board.func_code(board.req_op),
                     board.echo_word[31:24], board.echo_word[23:16],
                     board.echo_word[15:8], board.echo_word[7:0]};
        end
        if (corrupt == 2) begin
            int k;
            k = $urandom_range(bytes.size() - 1);
            bytes[k] = bytes[k] ^ (8'd1 << $urandom_range(7));
        end
        foreach (bytes[i]) begin
            if (!board.busy) break;
            send_rx(bytes[i]);
        end
        // Pad any frame whose length was corrupted upward, until it closes.
        while (board.busy) send_rx(8'($urandom));
    endtask

    task automatic random_request();
        logic [1:0]  op;
        logic [15:0] qv;
        op = 2'($urandom);
        case ($urandom_range(9))
            0: qv = 16'($urandom);
            1: qv = ((op == mbtc_pkg::OP_READ_COILS) ? mbtc_pkg::MAX_COILS
                                                     : mbtc_pkg::MAX_REGS) + 16'd1;
            default: qv = (op == mbtc_pkg::OP_READ_REGS || op == mbtc_pkg::OP_READ_COILS) ?
                          16'($urandom_range(1, 6)) : 16'($urandom);
        endcase
        send_item(mbtc_pkg::CMD_REQUEST, op, 16'($urandom), qv, 8'($urandom));
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (board.fault || r < 4)
                send_item(mbtc_pkg::CMD_RECONNECT, 2'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom));
            else if (r < 8) send_item(CMD_UNUSED, 2'($urandom), 16'($urandom),
                                      16'($urandom), 8'($urandom));
            else if (r < 12) send_rx(8'($urandom));
            else begin
                random_request();
                if (board.busy) begin
                    r = $urandom_range(99);
                    if (r < 5) random_request();
                    send_response(r < 70 ? 0 : (r < 80 ? 1 : 2));
                end
            end
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        command = 0;
        operation = 0;
        start_address = 0;
        quantity_or_value = 0;
        rx_byte = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: bad counts, extremes, stray byte, busy, possible exception, reconnect.
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_COILS, 0, 0, 0);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_COILS, 0, 2001, 0);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_REGS, 0, 126, 0);
        send_rx(8'hFF);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_REGS, 16'hFFFF, 16'd4, 8'hFF);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_WRITE_REG, 0, 0, 0);
        send_response(0);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_WRITE_COIL, 16'hFFFF, 16'hFFFF, 0);
        send_response(1);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_COILS, 16'h1234,
                  mbtc_pkg::MAX_COILS, 0);
        send_rx(8'h00); send_rx(8'h00); send_rx(8'h00); send_rx(8'h00);
        send_rx(8'h00); send_rx(8'h02); send_rx(8'h00);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_WRITE_REG, 0, 0, 0);
        send_item(mbtc_pkg::CMD_RECONNECT, 0, 0, 0, 0);
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_WRITE_REG, 0, 16'hFFFF, 0);
        send_rx(8'h00); send_rx(8'h01); send_rx(8'h00); send_rx(8'h00);
        send_rx(8'h01); send_rx(8'h00); send_rx(8'h00);
        send_item(mbtc_pkg::CMD_RECONNECT, 0, 0, 0, 0);
        send_item(CMD_UNUSED, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF);

        // Long receiver hold-off while requests keep arriving.
        hold_off_cycles = 200;
        send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_REGS, 5, 3, 0);
        for (int i = 0; i < 4; i++)
            send_item(mbtc_pkg::CMD_REQUEST, mbtc_pkg::OP_READ_REGS, 5, 3, 0);
        send_response(0);

        write_unit(8'h00);
        random_phase(4);
        send_idle_pct = 79;
        write_unit(8'hFF);
        random_phase(4);
        send_idle_pct = 0;
        recv_stall_pct = 79;
        write_unit(8'($urandom));
        random_phase(4);
        send_idle_pct = 25;
        recv_stall_pct = 25;
        write_unit(mbtc_pkg::UNIT_ID_RESET);
        random_phase(4);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(4);

        while (board.pending_results.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
